// File: rtl/mms_pkg.sv
`timescale 1ns / 1ps

package mms_pkg;

	localparam int LEVEL_W   = 16;
	localparam int ROUTE_W   = 39;
	localparam int ROUTE_REGS = 7;
	localparam int CFG_IDX_W = 4;
	localparam int SEL_W     = 3;
	localparam int VALUE_W   = 16;
	localparam int PROD_W    = 34;
	localparam int STEP_W    = 19;
	localparam int ACC_W     = 22;

	localparam logic [LEVEL_W-1:0] SLEW_ONE = 16'd32768;
	localparam logic signed [ACC_W-1:0] SUM_LIMIT = 22'sd16384;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE_FIRST = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE_LAST  = 4'd7;

	// input function codes
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// source codes
	localparam logic [SEL_W-1:0] SRC_ENV1     = 3'd0;
	localparam logic [SEL_W-1:0] SRC_ENV2     = 3'd1;
	localparam logic [SEL_W-1:0] SRC_FOLLOWER = 3'd2;
	localparam logic [SEL_W-1:0] SRC_GATE     = 3'd3;

	typedef struct packed {
		logic [LEVEL_W-1:0]        coef;
		logic signed [VALUE_W-1:0] amount;
		logic [SEL_W-1:0]          dst;
		logic [SEL_W-1:0]          src;
		logic                      valid;
	} route_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL1  = 7'b0000010,
		ST_UPD   = 7'b0000100,
		ST_MUL2  = 7'b0001000,
		ST_ACC   = 7'b0010000,
		ST_CLAMP = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

endpackage

// File: rtl/modulation_matrix_slewed_top.sv
`timescale 1ns / 1ps

// Slewed modulation matrix. A tick transaction (func 0) with the matrix enabled
// visits routes 0..NUM_ROUTES-1 in turn through one shared 17x17 multiplier:
// a valid route steps through MUL1 (slew product), UPD (slew update), MUL2
// (amount product) and ACC (accumulate), an invalid one is skipped in MUL1.
// The CLAMP state follows, then the NUM_DESTS destination sums go out one per
// transaction, and the sequencer returns to idle before the next input is
// taken. A disabled tick goes straight to the output run; a clear transaction
// returns no results. in_ready is high only while the sequencer is idle;
// configuration writes are always taken and should be made only while idle.
module modulation_matrix_slewed_top #(
	parameter int NUM_ROUTES = 7,
	parameter int NUM_DESTS  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mms_pkg::ROUTE_W-1:0]      cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             func,
	input  logic [mms_pkg::LEVEL_W-1:0]      env1_level,
	input  logic [mms_pkg::LEVEL_W-1:0]      env2_level,
	input  logic [mms_pkg::LEVEL_W-1:0]      follower_level,
	input  logic [mms_pkg::LEVEL_W-1:0]      gate_level,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mms_pkg::SEL_W-1:0]        dest_index,
	output logic signed [mms_pkg::VALUE_W-1:0] mod_value,
	output logic                             last
);
	import mms_pkg::*;

	localparam int RW = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
	localparam int DW = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;

	state_t state_q, state_d;

	logic                      enabled_q;
	route_t                    route_q [ROUTE_REGS];
	logic [LEVEL_W-1:0]        smooth_q [NUM_ROUTES];
	logic signed [ACC_W-1:0]   acc_q [NUM_DESTS];
	logic signed [VALUE_W-1:0] held_q [NUM_DESTS];
	logic [LEVEL_W-1:0]        env1_q, env2_q, follower_q, gate_q;
	logic [RW-1:0]             rt_q;
	logic [DW-1:0]             out_idx_q;
	logic signed [PROD_W-1:0]  prod_q;

	route_t                    rt_word;
	logic [LEVEL_W-1:0]        s_cur;
	logic [LEVEL_W-1:0]        target;
	logic [LEVEL_W-1:0]        coef_sat;
	logic signed [16:0]        mul_a, mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [STEP_W-1:0]  slew_step, s_sum, contrib;
	logic [LEVEL_W-1:0]        s_new;
	logic                      rt_last;
	logic                      dst_ok;
	logic                      in_acc, out_acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	assign rt_word  = route_q[3'(rt_q)];
	assign s_cur    = smooth_q[rt_q];
	assign rt_last  = (rt_q == RW'(NUM_ROUTES - 1));
	assign coef_sat = (rt_word.coef > SLEW_ONE) ? SLEW_ONE : rt_word.coef;
	assign dst_ok   = ({1'b0, rt_word.dst} < 4'(NUM_DESTS));

	always_comb begin
		case (rt_word.src)
			SRC_ENV1:     target = env1_q;
			SRC_ENV2:     target = env2_q;
			SRC_FOLLOWER: target = follower_q;
			SRC_GATE:     target = gate_q;
			default:      target = '0;
		endcase
	end

	// shared multiplier: slew step in MUL1, amount scaling in MUL2
	always_comb begin
		if (state_q == ST_MUL1) begin
			mul_a = $signed({1'b0, target}) - $signed({1'b0, s_cur});
			mul_b = $signed({1'b0, coef_sat});
		end else begin
			mul_a = $signed({1'b0, s_cur});
			mul_b = $signed({rt_word.amount[VALUE_W-1], rt_word.amount});
		end
	end
	assign mul_p = mul_a * mul_b;

	assign slew_step = STEP_W'(prod_q >>> 15);
	assign s_sum     = $signed({3'b000, s_cur}) + slew_step;
	assign contrib   = STEP_W'(prod_q >>> 14);

	always_comb begin
		if (s_sum < 0)
			s_new = '0;
		else if (s_sum > $signed(19'd65535))
			s_new = 16'hFFFF;
		else
			s_new = s_sum[LEVEL_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && func == FUNC_TICK)
					state_d = enabled_q ? ST_MUL1 : ST_EMIT;
			end
			ST_MUL1: begin
				if (!rt_word.valid)
					state_d = rt_last ? ST_CLAMP : ST_MUL1;
				else
					state_d = ST_UPD;
			end
			ST_UPD:   state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_ACC;
			ST_ACC:   state_d = rt_last ? ST_CLAMP : ST_MUL1;
			ST_CLAMP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_acc && out_idx_q == DW'(NUM_DESTS - 1))
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			enabled_q <= 1'b0;
			rt_q      <= '0;
			out_idx_q <= '0;
			for (int i = 0; i < ROUTE_REGS; i++)
				route_q[i] <= '0;
			for (int i = 0; i < NUM_ROUTES; i++)
				smooth_q[i] <= '0;
			for (int i = 0; i < NUM_DESTS; i++)
				held_q[i] <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ENABLED)
					enabled_q <= cfg_data[0];
				else if (cfg_index >= REG_ROUTE_FIRST && cfg_index <= REG_ROUTE_LAST)
					route_q[3'(cfg_index - REG_ROUTE_FIRST)] <= cfg_data;
			end

			if (in_acc && func == FUNC_CLEAR) begin
				for (int i = 0; i < NUM_ROUTES; i++)
					smooth_q[i] <= '0;
				for (int i = 0; i < NUM_DESTS; i++)
					held_q[i] <= '0;
			end

			if (in_acc)
				rt_q <= '0;
			else if ((state_q == ST_MUL1 && !rt_word.valid) || state_q == ST_ACC)
				rt_q <= rt_last ? '0 : rt_q + 1'b1;

			if (state_q == ST_UPD)
				smooth_q[rt_q] <= s_new;

			if (state_q == ST_CLAMP) begin
				for (int i = 0; i < NUM_DESTS; i++) begin
					if (acc_q[i] > SUM_LIMIT)
						held_q[i] <= VALUE_W'(SUM_LIMIT);
					else if (acc_q[i] < -SUM_LIMIT)
						held_q[i] <= VALUE_W'(-SUM_LIMIT);
					else
						held_q[i] <= acc_q[i][VALUE_W-1:0];
				end
			end

			if (in_acc)
				out_idx_q <= '0;
			else if (out_acc)
				out_idx_q <= (out_idx_q == DW'(NUM_DESTS - 1)) ? '0 : out_idx_q + 1'b1;
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			env1_q     <= env1_level;
			env2_q     <= env2_level;
			follower_q <= follower_level;
			gate_q     <= gate_level;
			for (int i = 0; i < NUM_DESTS; i++)
				acc_q[i] <= '0;
		end else if (state_q == ST_ACC && dst_ok) begin
			acc_q[rt_word.dst[DW-1:0]] <= acc_q[rt_word.dst[DW-1:0]] + ACC_W'(contrib);
		end
		if (state_q == ST_MUL1 || state_q == ST_MUL2)
			prod_q <= mul_p;
	end

	assign dest_index = SEL_W'(out_idx_q);
	assign mod_value  = held_q[out_idx_q];
	assign last       = (out_idx_q == DW'(NUM_DESTS - 1));

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while results pending");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> (!out_valid && in_ready))
		else $error("output run did not end after last");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mod_value <= 16'sd16384 && mod_value >= -16'sd16384))
		else $error("modulation value outside clamp range");

	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == FUNC_CLEAR) |=> (in_ready && !out_valid))
		else $error("clear produced results");

	a_first_dest: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (dest_index == '0))
		else $error("output run did not start at destination zero");

endmodule
